### rtl/assert_macros.svh
// Assertion macros for the RTL files that check themselves.
// Every macro assumes a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/tias_pkg.sv
// Shared types and constants for the tile id to atlas and screen block.
// No dependencies; every RTL module imports this package.
package tias_pkg;

	localparam int NUM_TILESETS_DEF = 4;
	localparam int MAP_DIM          = 1024;

	localparam int ID_W     = 16;
	localparam int MAP_W    = 10;
	localparam int TILE_W   = 9;
	localparam int CAM_W    = 16;
	localparam int CFG_W    = 48;
	localparam int DIV_W    = 16;
	localparam int SRC_X_W  = 16;
	localparam int SRC_Y_W  = 24;
	localparam int DST_W    = 20;

	localparam logic [TILE_W-1:0] TILE_WIDTH_RST  = 9'd16;
	localparam logic [TILE_W-1:0] TILE_HEIGHT_RST = 9'd16;

	typedef enum logic [2:0] {
		CFG_TILE_WIDTH  = 3'd0,
		CFG_TILE_HEIGHT = 3'd1,
		CFG_CAMERA_X    = 3'd2,
		CFG_CAMERA_Y    = 3'd3,
		CFG_TILESET_0   = 3'd4,
		CFG_TILESET_1   = 3'd5,
		CFG_TILESET_2   = 3'd6,
		CFG_TILESET_3   = 3'd7
	} tias_cfg_idx_t;

	// Fields that ride along with a request through the divider.
	typedef struct packed {
		logic             drawn;
		logic [1:0]       set_index;
		logic [DST_W-1:0] dst_x;
		logic [DST_W-1:0] dst_y;
	} tias_side_t;

endpackage

### rtl/tias_cols.sv
// Computes the tile column count of each tileset image (image width / tile width)
// with a bit-serial divider each time start is raised. Uses tias_pkg.
module tias_cols #(
	parameter int NUM_SETS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tias_pkg::TILE_W-1:0]   tile_width,
	input  logic [tias_pkg::DIV_W-1:0]    image_w [NUM_SETS],
	output logic                          busy,
	output logic [tias_pkg::DIV_W-1:0]    cols [NUM_SETS]
);
	import tias_pkg::*;

	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int BIT_W = $clog2(DIV_W);

	typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_RUN} state_t;

	state_t             state_q;
	logic [SET_W-1:0]   set_cnt_q;
	logic [BIT_W-1:0]   bit_cnt_q;
	logic [DIV_W-1:0]   num_q;
	logic [TILE_W-1:0]  rem_q;
	logic [DIV_W-1:0]   cols_q [NUM_SETS];

	logic [DIV_W-1:0]   img_sel;
	logic [TILE_W:0]    shifted;
	logic               ge;
	logic [TILE_W-1:0]  rem_next;
	logic [DIV_W-1:0]   num_next;

	always_comb begin
		img_sel = '0;
		for (int k = 0; k < NUM_SETS; k++) begin
			if (set_cnt_q == SET_W'(k)) begin
				img_sel = image_w[k];
			end
		end
	end

	// The quotient bits shift into the dividend register as its bits are used up.
	assign shifted  = {rem_q, num_q[DIV_W-1]};
	assign ge       = shifted >= {1'b0, tile_width};
	assign rem_next = ge ? TILE_W'(shifted - {1'b0, tile_width}) : shifted[TILE_W-1:0];
	assign num_next = {num_q[DIV_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			set_cnt_q <= '0;
			bit_cnt_q <= '0;
			num_q     <= '0;
			rem_q     <= '0;
			for (int k = 0; k < NUM_SETS; k++) begin
				cols_q[k] <= '0;
			end
		end else if (start) begin
			state_q   <= ST_LOAD;
			set_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_LOAD: begin
					num_q     <= img_sel;
					rem_q     <= '0;
					bit_cnt_q <= '0;
					state_q   <= ST_RUN;
				end
				ST_RUN: begin
					num_q     <= num_next;
					rem_q     <= rem_next;
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == BIT_W'(DIV_W - 1)) begin
						for (int k = 0; k < NUM_SETS; k++) begin
							if (set_cnt_q == SET_W'(k)) begin
								cols_q[k] <= (tile_width == '0) ? '0 : num_next;
							end
						end
						if (set_cnt_q == SET_W'(NUM_SETS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							set_cnt_q <= set_cnt_q + 1'b1;
							state_q   <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign cols = cols_q;

endmodule

### rtl/tias_div.sv
// Pipelined restoring divider, one quotient bit per stage, with per-stage stall.
// Carries a tias_pkg::tias_side_t sideband alongside each request.
module tias_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  tias_pkg::tias_side_t        in_side,
	input  logic [tias_pkg::DIV_W-1:0]  dividend,
	input  logic [tias_pkg::DIV_W-1:0]  divisor,
	output logic                        out_valid,
	input  logic                        out_ready,
	output tias_pkg::tias_side_t        out_side,
	output logic [tias_pkg::DIV_W-1:0]  quotient,
	output logic [tias_pkg::DIV_W-1:0]  remainder
);
	import tias_pkg::*;

	logic             vld_s2 [DIV_W];
	logic [DIV_W-1:0] num_s2 [DIV_W];
	logic [DIV_W-1:0] rem_s2 [DIV_W];
	logic [DIV_W-1:0] den_s2 [DIV_W];
	tias_side_t       side_s2 [DIV_W];
	logic [DIV_W:0]   rdy;

	assign rdy[DIV_W] = out_ready;

	for (genvar k = 0; k < DIV_W; k++) begin : g_stage
		logic             vld_prev;
		logic [DIV_W-1:0] num_prev;
		logic [DIV_W-1:0] rem_prev;
		logic [DIV_W-1:0] den_prev;
		tias_side_t       side_prev;
		logic [DIV_W:0]   shifted;
		logic             ge;

		if (k == 0) begin : g_first
			assign vld_prev  = in_valid;
			assign num_prev  = dividend;
			assign rem_prev  = '0;
			assign den_prev  = divisor;
			assign side_prev = in_side;
		end else begin : g_next
			assign vld_prev  = vld_s2[k-1];
			assign num_prev  = num_s2[k-1];
			assign rem_prev  = rem_s2[k-1];
			assign den_prev  = den_s2[k-1];
			assign side_prev = side_s2[k-1];
		end

		// A stage takes new data when it is empty or its successor moves on.
		assign rdy[k]  = !vld_s2[k] || rdy[k+1];
		assign shifted = {rem_prev, num_prev[DIV_W-1]};
		assign ge      = shifted >= {1'b0, den_prev};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s2[k] <= vld_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				num_s2[k]  <= {num_prev[DIV_W-2:0], ge};
				rem_s2[k]  <= ge ? DIV_W'(shifted - {1'b0, den_prev}) : shifted[DIV_W-1:0];
				den_s2[k]  <= den_prev;
				side_s2[k] <= side_prev;
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s2[DIV_W-1];
	assign out_side  = side_s2[DIV_W-1];
	assign quotient  = num_s2[DIV_W-1];
	assign remainder = rem_s2[DIV_W-1];

endmodule

### rtl/tile_id_to_atlas_and_screen_core.sv
// Tile id to atlas and screen position. Stages from the accepting edge to the result on the
// output: tileset match, 16 divider stages, then the source multiply stage. Throughput one
// tile per cycle while neither draw_stall nor a column count sweep holds it, set by the
// pipelined divider of local id by column count. A write to tile_width or a tileset starts a
// column count sweep over all tilesets; tiles and further writes stall until it ends. Reset
// is asynchronous, active low, and restores the configuration registers and an empty pipeline.
`include "assert_macros.svh"

module tile_id_to_atlas_and_screen_core #(
	parameter int NUM_TILESETS = tias_pkg::NUM_TILESETS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                tile_valid,
	output logic                                tile_stall,
	input  logic [tias_pkg::ID_W-1:0]           tile_id,
	input  logic [tias_pkg::MAP_W-1:0]          map_row,
	input  logic [tias_pkg::MAP_W-1:0]          map_col,
	output logic                                draw_valid,
	input  logic                                draw_stall,
	output logic                                drawn,
	output logic [1:0]                          set_index,
	output logic [tias_pkg::SRC_X_W-1:0]        src_x,
	output logic [tias_pkg::SRC_Y_W-1:0]        src_y,
	output logic signed [tias_pkg::DST_W-1:0]   dst_x,
	output logic signed [tias_pkg::DST_W-1:0]   dst_y,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  tias_pkg::tias_cfg_idx_t             cfg_index,
	input  logic [tias_pkg::CFG_W-1:0]          cfg_data
);
	import tias_pkg::*;

	// Configuration registers.
	logic [TILE_W-1:0] tile_width_q;
	logic [TILE_W-1:0] tile_height_q;
	logic [CAM_W-1:0]  camera_x_q;
	logic [CAM_W-1:0]  camera_y_q;
	logic [CFG_W-1:0]  tileset_q [NUM_TILESETS];

	logic              cfg_wr;
	logic              cols_start;
	logic              cols_busy;
	logic [DIV_W-1:0]  image_w [NUM_TILESETS];
	logic [DIV_W-1:0]  cols [NUM_TILESETS];

	assign cfg_ready  = !cols_busy;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign cols_start = cfg_wr && (cfg_index == CFG_TILE_WIDTH || cfg_index == CFG_TILESET_0
		|| cfg_index == CFG_TILESET_1 || cfg_index == CFG_TILESET_2
		|| cfg_index == CFG_TILESET_3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q  <= TILE_WIDTH_RST;
			tile_height_q <= TILE_HEIGHT_RST;
			camera_x_q    <= '0;
			camera_y_q    <= '0;
			for (int k = 0; k < NUM_TILESETS; k++) begin
				tileset_q[k] <= '0;
			end
		end else if (cfg_wr) begin
			if (cfg_index == CFG_TILE_WIDTH)  tile_width_q  <= cfg_data[TILE_W-1:0];
			if (cfg_index == CFG_TILE_HEIGHT) tile_height_q <= cfg_data[TILE_W-1:0];
			if (cfg_index == CFG_CAMERA_X)    camera_x_q    <= cfg_data[CAM_W-1:0];
			if (cfg_index == CFG_CAMERA_Y)    camera_y_q    <= cfg_data[CAM_W-1:0];
			for (int k = 0; k < NUM_TILESETS; k++) begin
				if (cfg_index == tias_cfg_idx_t'(CFG_TILESET_0 + k)) begin
					tileset_q[k] <= cfg_data;
				end
			end
		end
	end

	for (genvar k = 0; k < NUM_TILESETS; k++) begin : g_img
		assign image_w[k] = tileset_q[k][15:0];
	end

	tias_cols #(
		.NUM_SETS(NUM_TILESETS)
	) u_cols (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cols_start),
		.tile_width(tile_width_q),
		.image_w   (image_w),
		.busy      (cols_busy),
		.cols      (cols)
	);

	// Stage 1: tileset match, local id and screen position.
	logic              hit_any;
	logic [1:0]        sel_c;
	logic [ID_W-1:0]   first_c;
	logic [DIV_W-1:0]  cols_c;
	logic              in_map;
	logic              drawn_c;
	logic [18:0]       px_c;
	logic [18:0]       py_c;
	tias_side_t        side_c;

	always_comb begin
		hit_any = 1'b0;
		sel_c   = '0;
		first_c = '0;
		cols_c  = '0;
		// Walking down from the top leaves the lowest matching tileset selected.
		for (int k = NUM_TILESETS - 1; k >= 0; k--) begin
			if (tileset_q[k][47:32] <= tile_id
				&& (tile_id - tileset_q[k][47:32]) < tileset_q[k][31:16]) begin
				hit_any = 1'b1;
				sel_c   = 2'(k);
				first_c = tileset_q[k][47:32];
				cols_c  = cols[k];
			end
		end
	end

	assign in_map  = ({1'b0, map_row} < 11'(MAP_DIM)) && ({1'b0, map_col} < 11'(MAP_DIM));
	assign drawn_c = (tile_id != '0) && in_map && hit_any && (tile_width_q != '0)
		&& (cols_c != '0);
	assign px_c    = 19'(map_col) * 19'(tile_width_q);
	assign py_c    = 19'(map_row) * 19'(tile_height_q);

	assign side_c.drawn     = drawn_c;
	assign side_c.set_index = sel_c;
	assign side_c.dst_x     = DST_W'(px_c) - {{(DST_W-CAM_W){camera_x_q[CAM_W-1]}}, camera_x_q};
	assign side_c.dst_y     = DST_W'(py_c) - {{(DST_W-CAM_W){camera_y_q[CAM_W-1]}}, camera_y_q};

	logic              vld_s1;
	tias_side_t        side_s1;
	logic [DIV_W-1:0]  local_s1;
	logic [DIV_W-1:0]  cols_s1;
	logic              div_in_ready;
	logic              ready_s1;

	assign ready_s1   = !vld_s1 || div_in_ready;
	assign tile_stall = !ready_s1 || cols_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ready_s1) begin
			vld_s1 <= tile_valid && !cols_busy;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			side_s1  <= side_c;
			local_s1 <= tile_id - first_c;
			cols_s1  <= cols_c;
		end
	end

	// Divider: local id by column count.
	logic              div_out_valid;
	logic              div_out_ready;
	tias_side_t        div_side;
	logic [DIV_W-1:0]  div_quo;
	logic [DIV_W-1:0]  div_rem;

	tias_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s1),
		.in_ready (div_in_ready),
		.in_side  (side_s1),
		.dividend (local_s1),
		.divisor  (cols_s1),
		.out_valid(div_out_valid),
		.out_ready(div_out_ready),
		.out_side (div_side),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// Stage 3: source position and output register.
	logic [24:0]          sx_full;
	logic [24:0]          sy_full;
	logic                 vld_s3;
	logic                 drawn_s3;
	logic [1:0]           set_s3;
	logic [SRC_X_W-1:0]   src_x_s3;
	logic [SRC_Y_W-1:0]   src_y_s3;
	logic [DST_W-1:0]     dst_x_s3;
	logic [DST_W-1:0]     dst_y_s3;

	assign sx_full       = 25'(div_rem) * 25'(tile_width_q);
	assign sy_full       = 25'(div_quo) * 25'(tile_height_q);
	assign div_out_ready = !vld_s3 || !draw_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (div_out_ready) begin
			vld_s3 <= div_out_valid;
		end
	end

	// A skipped tile reports zero in every field.
	always_ff @(posedge clk) begin
		if (div_out_ready) begin
			drawn_s3 <= div_side.drawn;
			set_s3   <= div_side.drawn ? div_side.set_index : '0;
			src_x_s3 <= div_side.drawn ? sx_full[SRC_X_W-1:0] : '0;
			src_y_s3 <= div_side.drawn ? sy_full[SRC_Y_W-1:0] : '0;
			dst_x_s3 <= div_side.drawn ? div_side.dst_x : '0;
			dst_y_s3 <= div_side.drawn ? div_side.dst_y : '0;
		end
	end

	assign draw_valid = vld_s3;
	assign drawn      = drawn_s3;
	assign set_index  = set_s3;
	assign src_x      = src_x_s3;
	assign src_y      = src_y_s3;
	assign dst_x      = dst_x_s3;
	assign dst_y      = dst_y_s3;

	logic skip_fields_zero;

	assign skip_fields_zero = set_index == '0 && src_x == '0 && src_y == '0
		&& dst_x == '0 && dst_y == '0;

	`ASSERT_IMPLIES(a_no_tile_during_sweep, tile_valid && !tile_stall, !cols_busy, "tile in sweep")
	`ASSERT_IMPLIES(a_skip_is_zero, draw_valid && !drawn, skip_fields_zero, "nonzero skip")
	`ASSERT_IMPLIES(a_sweep_from_write, $rose(cols_busy), $past(cols_start), "sweep without write")

endmodule

### bench/tb.sv
// Self-checking bench for tile_id_to_atlas_and_screen_core: random and directed tiles under
// many register settings, results checked against an in-bench model of the tile placement.
// Depends on tias_pkg and the core; no files are read.
`timescale 1ns / 100ps

module tb;
	import tias_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;

	typedef struct packed {
		logic [TILE_W-1:0]      tile_w;
		logic [TILE_W-1:0]      tile_h;
		logic [CAM_W-1:0]       cam_x;
		logic [CAM_W-1:0]       cam_y;
		logic [3:0][CFG_W-1:0]  sets;
	} tile_cfg_t;

	typedef struct packed {
		logic               drawn;
		logic [1:0]         set_index;
		logic [SRC_X_W-1:0] src_x;
		logic [SRC_Y_W-1:0] src_y;
		logic [DST_W-1:0]   dst_x;
		logic [DST_W-1:0]   dst_y;
	} draw_t;

	logic                     clk;
	logic                     arst_n;
	logic                     tile_valid;
	logic                     tile_stall;
	logic [ID_W-1:0]          tile_id;
	logic [MAP_W-1:0]         map_row;
	logic [MAP_W-1:0]         map_col;
	logic                     draw_valid;
	logic                     draw_stall;
	logic                     drawn;
	logic [1:0]               set_index;
	logic [SRC_X_W-1:0]       src_x;
	logic [SRC_Y_W-1:0]       src_y;
	logic signed [DST_W-1:0]  dst_x;
	logic signed [DST_W-1:0]  dst_y;
	logic                     cfg_valid;
	logic                     cfg_ready;
	tias_cfg_idx_t            cfg_index;
	logic [CFG_W-1:0]         cfg_data;

	tile_cfg_t live_cfg;
	draw_t     pending_draws[$];
	bit        idle_mix;
	int        errors;
	int        tiles_sent;
	int        draws_checked;
	int        drawn_seen;
	int        settings_applied;
	int        cycles;

	tile_id_to_atlas_and_screen_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tile_valid (tile_valid),
		.tile_stall (tile_stall),
		.tile_id    (tile_id),
		.map_row    (map_row),
		.map_col    (map_col),
		.draw_valid (draw_valid),
		.draw_stall (draw_stall),
		.drawn      (drawn),
		.set_index  (set_index),
		.src_x      (src_x),
		.src_y      (src_y),
		.dst_x      (dst_x),
		.dst_y      (dst_y),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("tb NOT OK");
			$finish;
		end
	end

	// Where a tile lands in its tileset image and on screen, under the current registers.
	function automatic draw_t place_tile(input logic [ID_W-1:0] id,
			input logic [MAP_W-1:0] row, input logic [MAP_W-1:0] col);
		draw_t d;
		int k;
		int hit;
		longint unsigned first, count, img, width, cols, local_id;
		longint sx, sy;
		d = '0;
		hit = -1;
		first = 0;
		img = 0;
		width = live_cfg.tile_w;
		if (id == 0 || row >= MAP_DIM || col >= MAP_DIM)
			return d;
		for (k = 0; k < NUM_TILESETS_DEF && hit < 0; k++) begin
			first = live_cfg.sets[k][47:32];
			count = live_cfg.sets[k][31:16];
			if (id >= first && id - first < count) begin
				hit = k;
				img = live_cfg.sets[k][15:0];
			end
		end
		if (hit < 0 || width == 0)
			return d;
		cols = img / width;
		if (cols == 0)
			return d;
		local_id = id - first;
		d.drawn = 1'b1;
		d.set_index = hit[1:0];
		d.src_x = SRC_X_W'((local_id % cols) * width);
		d.src_y = SRC_Y_W'((local_id / cols) * longint'(live_cfg.tile_h));
		sx = longint'(col) * longint'(width) - longint'($signed(live_cfg.cam_x));
		sy = longint'(row) * longint'(live_cfg.tile_h) - longint'($signed(live_cfg.cam_y));
		d.dst_x = sx[DST_W-1:0];
		d.dst_y = sy[DST_W-1:0];
		return d;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_mix || r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [CFG_W-1:0] pack_set(input int first, input int count,
			input int width);
		return {16'(first), 16'(count), 16'(width)};
	endfunction

	function automatic logic [TILE_W-1:0] random_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return '0;
		if (r < 8)
			return TILE_W'($urandom_range(257, 511));
		if (r < 12)
			return (r < 10) ? TILE_W'(1) : TILE_W'(256);
		if (r < 70)
			return TILE_W'($urandom_range(1, 32));
		return TILE_W'($urandom_range(33, 256));
	endfunction

	function automatic logic [CAM_W-1:0] random_camera();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return CAM_W'($urandom);
		endcase
	endfunction

	function automatic tile_cfg_t random_setting();
		tile_cfg_t c;
		int k;
		c.tile_w = random_size();
		c.tile_h = random_size();
		c.cam_x = random_camera();
		c.cam_y = random_camera();
		for (k = 0; k < 4; k++) begin
			case ($urandom_range(0, 9))
				0: c.sets[k] = {16'($urandom), 32'($urandom)};
				1: c.sets[k] = pack_set($urandom_range(0, 3000), 0, $urandom);
				2: c.sets[k] = pack_set($urandom_range(65000, 65535),
						$urandom_range(1, 65535), $urandom);
				default: c.sets[k] = pack_set($urandom_range(0, 3000),
						$urandom_range(1, 1500),
						c.tile_w * $urandom_range(0, 30) + $urandom_range(0, 15));
			endcase
		end
		return c;
	endfunction

	// Picks an id that mostly falls inside or at the edge of a configured tileset.
	function automatic logic [ID_W-1:0] random_id();
		int r;
		int k;
		longint unsigned first, count;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, 3);
		first = live_cfg.sets[k][47:32];
		count = live_cfg.sets[k][31:16];
		if (r < 8)
			return '0;
		if (r < 18)
			return ID_W'($urandom);
		if (r < 30) begin
			case ($urandom_range(0, 2))
				0: return ID_W'(first - 1);
				1: return ID_W'(first + count);
				default: return ID_W'(first + count - 1);
			endcase
		end
		if (count == 0)
			return ID_W'($urandom_range(1, 65535));
		return ID_W'(first + $urandom_range(0, count - 1));
	endfunction

	function automatic logic [MAP_W-1:0] random_pos();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return '1;
			default: return MAP_W'($urandom_range(0, MAP_DIM - 1));
		endcase
	endfunction

	task automatic send_tile(input logic [ID_W-1:0] id, input logic [MAP_W-1:0] row,
			input logic [MAP_W-1:0] col);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			tile_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tile_valid <= 1'b1;
		tile_id <= id;
		map_row <= row;
		map_col <= col;
		do @(posedge clk); while (tile_stall);
		pending_draws.push_back(place_tile(id, row, col));
		tiles_sent++;
	endtask

	task automatic send_random_tiles(input int count);
		int i;
		for (i = 0; i < count; i++)
			send_tile(random_id(), random_pos(), random_pos());
	endtask

	// Lowers the tile request and waits until every expected result has come back.
	task automatic drain();
		tile_valid <= 1'b0;
		do @(posedge clk); while (pending_draws.size() != 0);
	endtask

	// Writes all eight registers; junk above the size and camera fields checks that it is ignored.
	task automatic apply_config(input tile_cfg_t c);
		tias_cfg_idx_t regs[8];
		logic [CFG_W-1:0] vals[8];
		int i;
		regs = '{CFG_TILE_WIDTH, CFG_TILE_HEIGHT, CFG_CAMERA_X, CFG_CAMERA_Y,
			CFG_TILESET_0, CFG_TILESET_1, CFG_TILESET_2, CFG_TILESET_3};
		vals = '{{39'($urandom), c.tile_w}, {39'($urandom), c.tile_h},
			{32'($urandom), c.cam_x}, {32'($urandom), c.cam_y},
			c.sets[0], c.sets[1], c.sets[2], c.sets[3]};
		for (i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		live_cfg = c;
		settings_applied++;
	endtask

	task automatic check_field(input string name, input logic [SRC_Y_W-1:0] want,
			input logic [SRC_Y_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_draws
		draw_t want;
		if (arst_n && draw_valid && !draw_stall) begin
			if (pending_draws.size() == 0) begin
				errors++;
				$display("%0t: result with no tile pending, expected none got drawn=%b",
					$time, drawn);
			end else begin
				want = pending_draws.pop_front();
				draws_checked++;
				if (want.drawn)
					drawn_seen++;
				check_field("drawn", want.drawn, drawn);
				check_field("set_index", want.set_index, set_index);
				check_field("src_x", want.src_x, src_x);
				check_field("src_y", want.src_y, src_y);
				check_field("dst_x", want.dst_x, $unsigned(dst_x));
				check_field("dst_y", want.dst_y, $unsigned(dst_y));
			end
		end
	end

	// Receiver side: random stall bursts, switched off together with sender gaps.
	initial begin : draw_stall_gen
		int n;
		draw_stall = 1'b0;
		forever begin
			repeat ($urandom_range(1, 8)) @(posedge clk);
			n = pick_gap();
			if (n > 0) begin
				draw_stall <= 1'b1;
				repeat (n) @(posedge clk);
				draw_stall <= 1'b0;
			end
		end
	end

	// With every tileset empty after reset nothing can be drawn.
	task automatic test_reset_values();
		send_tile('0, '0, '0);
		send_tile(16'd1, 10'd3, 10'd4);
		send_tile('1, '1, '1);
		drain();
	endtask

	task automatic test_directed();
		tile_cfg_t c;
		// Adjacent sets 0 and 1 check the boundary between them; set 2 has no tiles.
		c.tile_w = 9'd16;
		c.tile_h = 9'd8;
		c.cam_x = 16'hFFFB;
		c.cam_y = 16'd100;
		c.sets[0] = pack_set(1, 64, 128);
		c.sets[1] = pack_set(65, 100, 256);
		c.sets[2] = pack_set(10, 0, 64);
		c.sets[3] = pack_set(1000, 200, 16);
		apply_config(c);
		send_tile(16'd0, 10'd5, 10'd5);
		send_tile(16'd1, 10'd0, 10'd0);
		send_tile(16'd8, 10'd0, 10'd1);
		send_tile(16'd9, 10'd3, 10'd4);
		send_tile(16'd10, 10'd2, 10'd2);
		send_tile(16'd64, 10'd1023, 10'd1023);
		send_tile(16'd65, 10'd0, 10'd0);
		send_tile(16'd164, 10'd7, 10'd9);
		send_tile(16'd165, 10'd7, 10'd9);
		send_tile(16'd1199, 10'd1, 10'd1);
		send_tile(16'hFFFF, 10'd1023, 10'd0);
		drain();

		// Zero tile width must never be drawn.
		c.tile_w = '0;
		c.tile_h = 9'd1;
		apply_config(c);
		send_tile(16'd1, 10'd0, 10'd0);
		send_tile(16'd70, 10'd5, 10'd5);
		drain();

		// Widest tiles and extreme camera; set 0 is narrower than one tile, and set 3
		// has one column so the source row runs past the 24-bit field.
		c.tile_w = 9'd511;
		c.tile_h = 9'd511;
		c.cam_x = 16'h8000;
		c.cam_y = 16'h7FFF;
		c.sets[0] = pack_set(100, 10, 300);
		c.sets[1] = pack_set(200, 50, 1100);
		c.sets[2] = pack_set(16'hFFF0, 16'hFFFF, 16'hFFFF);
		c.sets[3] = pack_set(0, 16'hFFFF, 511);
		apply_config(c);
		send_tile(16'd105, 10'd2, 10'd2);
		send_tile(16'd249, 10'd1023, 10'd1023);
		send_tile(16'hFFFF, 10'd1023, 10'd1023);
		send_tile(16'd3, 10'd0, 10'd0);
		send_tile(16'hFFEF, 10'd7, 10'd7);
		send_tile(16'd300, 10'd0, 10'd1023);
		drain();
	endtask

	// Full rate on both sides.
	task automatic test_back_to_back();
		idle_mix = 1'b0;
		apply_config(random_setting());
		send_random_tiles(300);
		drain();
		idle_mix = 1'b1;
	endtask

	task automatic test_random_settings();
		tile_cfg_t c;
		int p;
		for (p = 0; p < 10; p++) begin
			c = random_setting();
			if (p == 0) begin
				c.tile_w = 9'd1;
				c.tile_h = 9'd1;
				c.cam_x = 16'h7FFF;
				c.cam_y = 16'h8000;
			end else if (p == 1) begin
				c.tile_w = 9'd256;
				c.tile_h = 9'd256;
				c.cam_x = 16'h8000;
				c.cam_y = 16'h7FFF;
			end
			apply_config(c);
			send_random_tiles(150);
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		tile_valid = 1'b0;
		tile_id = '0;
		map_row = '0;
		map_col = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TILE_WIDTH;
		cfg_data = '0;
		idle_mix = 1'b1;
		live_cfg.tile_w = TILE_WIDTH_RST;
		live_cfg.tile_h = TILE_HEIGHT_RST;
		live_cfg.cam_x = '0;
		live_cfg.cam_y = '0;
		live_cfg.sets = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_directed();
		test_back_to_back();
		test_random_settings();

		drain();
		repeat (40) @(posedge clk);
		if (pending_draws.size() != 0) begin
			errors += pending_draws.size();
			$display("%0t: %0d expected results never arrived", $time, pending_draws.size());
		end
		$display("Placed %0d tiles under %0d register settings with random gaps and stalls;",
			tiles_sent, settings_applied);
		$display("%0d results compared, %0d of them drawn.", draws_checked, drawn_seen);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
